### rtl/mdb_pkg.sv
// Package with shared constants, types and helpers for the switch debouncer.
`timescale 1ns / 1ps

package mdb_pkg;

    // Number of debounced pins (one lane each).
    localparam int NUM_PINS = 8;

    // Widths of the stream fields and configuration registers.
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 8;
    localparam int OUT_W   = 8;
    localparam int CH_W    = 3;
    localparam int DELAY_W = 8;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 3;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_NC_MASK       = 3'd0;
    localparam logic [IDX_W-1:0] REG_EXTEND_CH     = 3'd1;
    localparam logic [IDX_W-1:0] REG_RETRACT_CH    = 3'd2;
    localparam logic [IDX_W-1:0] REG_EXTEND_DELAY  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RETRACT_DELAY = 3'd4;
    localparam logic [IDX_W-1:0] REG_BUTTON_DELAY  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [LEVEL_W-1:0] NC_MASK_RST     = 8'd0;
    localparam logic [CH_W-1:0]    EXTEND_CH_RST   = 3'd0;
    localparam logic [CH_W-1:0]    RETRACT_CH_RST  = 3'd1;
    localparam logic [DELAY_W-1:0] DELAY_RST       = 8'd10;

    // What one lane reports for the current word.
    typedef struct packed {
        logic stable;
        logic changed;
    } lane_res_t;

    // Debounce delay of a pin; the extend channel wins when both channel registers name the pin.
    function automatic logic [DELAY_W-1:0] delay_for(
        input int unsigned        pin,
        input logic [CH_W-1:0]    ext_ch,
        input logic [CH_W-1:0]    ret_ch,
        input logic [DELAY_W-1:0] ext_d,
        input logic [DELAY_W-1:0] ret_d,
        input logic [DELAY_W-1:0] btn_d
    );
        logic [DELAY_W-1:0] d;
        if (pin == 32'(ext_ch))
            d = ext_d;
        else if (pin == 32'(ret_ch))
            d = ret_d;
        else
            d = btn_d;
        return d;
    endfunction

endpackage

### rtl/multi_input_debouncer_top.sv
// Top level of the multi-input switch debouncer.
`timescale 1ns / 1ps

// Channel   Direction  Contents
// s_axis    in         tdata: now_ms[31:0], raw_levels[39:32]
// m_axis    out        tdata: debounced_states[7:0], changed_mask[15:8]
// cfg       in         cfg_we, cfg_index, cfg_data (registers 0 to 5)
//
// Every pin has its own lane; all lanes update in the cycle a word is accepted,
// so one word is taken per clock unless stalled; its result appears in the next cycle.
// The output register lets a new word in while the result is taken in the same cycle.
// A stalled output holds one result and stops input until it is taken.
// Reset clears the readings, stable states and timestamps and loads the default registers.

module multi_input_debouncer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // now_ms [31:0], raw_levels [39:32]
    input  logic [mdb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // debounced_states [7:0], changed_mask [15:8]
    output logic [mdb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [mdb_pkg::IDX_W-1:0]      cfg_index,
    input  logic [mdb_pkg::CFG_W-1:0]      cfg_data
);
    import mdb_pkg::*;

    logic [LEVEL_W-1:0] nc_mask_reg;
    logic [CH_W-1:0]    extend_ch_reg;
    logic [CH_W-1:0]    retract_ch_reg;
    logic [DELAY_W-1:0] extend_delay_reg;
    logic [DELAY_W-1:0] retract_delay_reg;
    logic [DELAY_W-1:0] button_delay_reg;

    logic [TIME_W-1:0]  now_ms;
    logic [LEVEL_W-1:0] raw_levels;
    logic               accept;
    lane_res_t          lane_res [NUM_PINS];

    assign now_ms     = s_axis_tdata[TIME_W-1:0];
    assign raw_levels = s_axis_tdata[TIME_W +: LEVEL_W];
    assign accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_mask_reg       <= NC_MASK_RST;
            extend_ch_reg     <= EXTEND_CH_RST;
            retract_ch_reg    <= RETRACT_CH_RST;
            extend_delay_reg  <= DELAY_RST;
            retract_delay_reg <= DELAY_RST;
            button_delay_reg  <= DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NC_MASK:       nc_mask_reg       <= cfg_data;
                REG_EXTEND_CH:     extend_ch_reg     <= cfg_data[CH_W-1:0];
                REG_RETRACT_CH:    retract_ch_reg    <= cfg_data[CH_W-1:0];
                REG_EXTEND_DELAY:  extend_delay_reg  <= cfg_data;
                REG_RETRACT_DELAY: retract_delay_reg <= cfg_data;
                REG_BUTTON_DELAY:  button_delay_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    generate
        for (genvar i = 0; i < NUM_PINS; i++)
        begin : g_lane
            logic               reading;
            logic [DELAY_W-1:0] delay_ms;

            // Pins above the level field see level low and no NC bit, so they read active.
            if (i < LEVEL_W)
            begin : g_wired
                assign reading = nc_mask_reg[i] ? raw_levels[i] : !raw_levels[i];
            end
            else
            begin : g_unwired
                assign reading = 1'b1;
            end

            assign delay_ms = delay_for(i, extend_ch_reg, retract_ch_reg,
                                        extend_delay_reg, retract_delay_reg,
                                        button_delay_reg);

            mdb_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .accept   (accept),
                .reading  (reading),
                .now_ms   (now_ms),
                .delay_ms (delay_ms),
                .res      (lane_res[i])
            );
        end
    endgenerate

    mdb_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .lane_res      (lane_res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### rtl/mdb_lane.sv
// One debounce lane: reading history, change timestamp and stable state of a pin.
`timescale 1ns / 1ps

module mdb_lane (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        reading,
    input  logic [mdb_pkg::TIME_W-1:0]  now_ms,
    input  logic [mdb_pkg::DELAY_W-1:0] delay_ms,
    output mdb_pkg::lane_res_t          res
);
    import mdb_pkg::*;

    logic              last_reg;
    logic              stable_reg;
    logic [TIME_W-1:0] change_time_reg;

    logic              last_next;
    logic              stable_next;
    logic [TIME_W-1:0] change_time_next;
    logic [TIME_W-1:0] elapsed;
    logic              changed;

    // A fresh edge restarts the timer from that word's timestamp; no change is reported for that word.
    always_comb
    begin
        elapsed = now_ms - change_time_reg;
        changed = (reading == last_reg) && (elapsed > TIME_W'(delay_ms))
                  && (last_reg != stable_reg);
        last_next        = reading;
        stable_next      = stable_reg ^ changed;
        change_time_next = (reading != last_reg) ? now_ms : change_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg        <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
        end
        else if (accept)
        begin
            last_reg        <= last_next;
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
        end
    end

    assign res.stable  = stable_next;
    assign res.changed = changed;

endmodule

### rtl/mdb_merge.sv
// Merging stage: gathers the lane results into one output word register.
`timescale 1ns / 1ps

module mdb_merge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mdb_pkg::lane_res_t             lane_res [mdb_pkg::NUM_PINS],
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mdb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mdb_pkg::*;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_W-1:0]      states;
    logic [OUT_W-1:0]      changes;
    logic                  load;

    // Pins beyond the output width are dropped; missing pins read as zero.
    generate
        for (genvar i = 0; i < OUT_W; i++)
        begin : g_bits
            if (i < NUM_PINS)
            begin : g_pin
                assign states[i]  = lane_res[i].stable;
                assign changes[i] = lane_res[i].changed;
            end
            else
            begin : g_pad
                assign states[i]  = 1'b0;
                assign changes[i] = 1'b0;
            end
        end
    endgenerate

    assign in_ready = !out_valid_reg || m_axis_tready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= {changes, states};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
